>>> rtl/core/bfd_pkg.sv
// Shared widths, defaults and lane arithmetic for the 2x2 box-filter downscaler.
package bfd_pkg;

  localparam int unsigned PixW        = 32;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned NumChan     = PixW / ChanW;
  localparam int unsigned LaneW       = ChanW + 1;
  localparam int unsigned PairW       = NumChan * LaneW;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned MaxWidthDef = 4096;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [PairW-1:0] pair_t;

  // Four 9-bit lanes, lane k = channel k of a + channel k of b.
  function automatic pair_t pair_sums(input pix_t a, input pix_t b);
    pair_t r;
    r = '0;
    for (int k = 0; k < NumChan; k++) begin
      r[k*LaneW +: LaneW] = {1'b0, a[k*ChanW +: ChanW]} + {1'b0, b[k*ChanW +: ChanW]};
    end
    return r;
  endfunction

  // Lane-wise upper + lower, divided by four, truncated to a channel.
  function automatic pix_t finish_average(input pair_t upper, input pair_t lower);
    pix_t                r;
    logic [LaneW:0]      s;
    r = '0;
    for (int k = 0; k < NumChan; k++) begin
      s = {1'b0, upper[k*LaneW +: LaneW]} + {1'b0, lower[k*LaneW +: LaneW]};
      r[k*ChanW +: ChanW] = s[LaneW:2];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bfd_if.sv
// Stream interfaces for the source pixel and the downscaled pixel channels.
interface bfd_in_if import bfd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;
  logic frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface bfd_out_if import bfd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic row_end;

  modport source (output valid, output pixel_out, output row_end, input ready);
  modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

>>> rtl/core/bfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module bfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/box_filter_2x2_downscale.sv
// Top level of the 2x2 box-filter downscaler (one mipmap level).
//
//   channel   dir   handshake       payload
//   sink_if   in    valid/ready     pixel_in[31:0], frame_start
//   src_if    out   valid/ready     pixel_out[31:0], row_end
//   cfg       in    cfg_we_i        cfg_wdata_i[12:0] = source_width
//
// One source pixel per cycle while input ready is high. An output beat leaves
// the output register after the odd-row, odd-column pixel that completes its
// square has passed the line-store read stage. The line store has one write
// and one read port; each beat uses at most one of them. Reset needs no
// clearing pass. A stalled output holds the read stage, and input ready drops
// only while both the read stage and the output register are full.
module box_filter_2x2_downscale import bfd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  bfd_in_if.sink          sink_if,
  bfd_out_if.source       src_if
);

  localparam int unsigned LineDepth = MAX_WIDTH / 2;
  localparam int unsigned AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned ColW      = $clog2(MAX_WIDTH);
  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW        = (WW > CfgW) ? WW : CfgW;
  localparam logic [XW-1:0] MaxX    = XW'(MAX_WIDTH);
  localparam logic [XW-1:0] MinX    = XW'(2);

  // Width in use, clamped and evened when written
  logic [WW-1:0]   width_q, width_d;
  logic [XW-1:0]   cfg_x, cfg_clamped;

  always_comb begin
    cfg_x = XW'(cfg_wdata_i);
    if (cfg_x < MinX) begin
      cfg_clamped = MinX;
    end else if (cfg_x > MaxX) begin
      cfg_clamped = MaxX;
    end else begin
      cfg_clamped = cfg_x;
    end
    width_d = cfg_we_i ? {cfg_clamped[WW-1:1], 1'b0} : width_q;
  end

  // Position and hold
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic            odd_q, odd_d, odd_cur;
  pix_t            hold_q, hold_d;
  logic            in_acc, row_done, odd_col;
  logic [WW-1:0]   col_next;
  pair_t           pair;
  logic [AddrW-1:0] slot;
  logic            line_we, line_re;
  pair_t           line_rdata;

  // Read stage and output register
  logic  s1_valid_q, s1_valid_d;
  pair_t s1_pair_q, s1_pair_d;
  logic  s1_end_q, s1_end_d;
  logic  out_valid_q, out_valid_d;
  pix_t  out_pix_q, out_pix_d;
  logic  out_end_q, out_end_d;
  logic  out_free, s1_adv;

  assign out_free      = !out_valid_q || src_if.ready;
  assign s1_adv        = s1_valid_q && out_free;
  assign sink_if.ready = !s1_valid_q || out_free;
  assign in_acc        = sink_if.valid && sink_if.ready;

  always_comb begin
    col_cur  = sink_if.frame_start ? '0 : col_q;
    odd_cur  = sink_if.frame_start ? 1'b0 : odd_q;
    col_next = WW'(col_cur) + WW'(1);
    row_done = (col_next >= width_q);
    odd_col  = col_cur[0];
    pair     = pair_sums(hold_q, sink_if.pixel_in);
    slot     = AddrW'(col_cur >> 1);
    line_we  = in_acc && odd_col && !odd_cur;
    line_re  = in_acc && odd_col && odd_cur;

    col_d  = col_q;
    odd_d  = odd_q;
    hold_d = hold_q;
    if (in_acc) begin
      if (!odd_col) begin
        hold_d = sink_if.pixel_in;
      end
      if (row_done) begin
        col_d = '0;
        odd_d = !odd_cur;
      end else begin
        col_d = ColW'(col_next);
        odd_d = odd_cur;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_pair_d  = s1_pair_q;
    s1_end_d   = s1_end_q;
    if (line_re) begin
      s1_valid_d = 1'b1;
      s1_pair_d  = pair;
      s1_end_d   = row_done;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_end_d   = out_end_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_pix_d   = finish_average(line_rdata, s1_pair_q);
      out_end_d   = s1_end_q;
    end else if (src_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  bfd_ram #(
    .Width (PairW),
    .Depth (LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (slot),
    .wdata_i (pair),
    .re_i    (line_re),
    .raddr_i (slot),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WW'(2);
      col_q       <= '0;
      odd_q       <= 1'b0;
      hold_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      col_q       <= col_d;
      odd_q       <= odd_d;
      hold_q      <= hold_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pair_q <= s1_pair_d;
    s1_end_q  <= s1_end_d;
    out_pix_q <= out_pix_d;
    out_end_q <= out_end_d;
  end

  assign src_if.valid     = out_valid_q;
  assign src_if.pixel_out = out_pix_q;
  assign src_if.row_end   = out_end_q;

endmodule

>>> rtl/core/bfd_checker.sv
// Port-level checks for the downscaler, bound to the top level.
module bfd_port_checks import bfd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input pix_t out_pixel_i,
  input logic out_row_end_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a new output beat always comes from an accepted input beat via the read stage
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("output beat without a matching input beat");

  // input is only held off while an output beat is waiting
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pixel_i) && $stable(out_row_end_i))
    else $error("output payload changed while stalled");

endmodule

bind box_filter_2x2_downscale bfd_port_checks u_bfd_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sink_if.valid),
  .in_ready_i    (sink_if.ready),
  .out_valid_i   (src_if.valid),
  .out_ready_i   (src_if.ready),
  .out_pixel_i   (src_if.pixel_out),
  .out_row_end_i (src_if.row_end)
);
